[sv/sctr_pkg.sv]
package sctr_pkg;

    localparam int unsigned SKIN_DEPTH = 65536;
    localparam int unsigned OUT_WIDTH  = 512;
    localparam int unsigned OUT_HEIGHT = 256;

    localparam int unsigned SKIN_AW    = $clog2(SKIN_DEPTH);
    localparam int unsigned ADDR_W     = 16;
    localparam int unsigned COLOR_W    = 32;
    localparam int unsigned TEXEL_W    = 8;
    localparam int unsigned PAL_AW     = 8;
    localparam int unsigned ROW_W      = 8;
    localparam int unsigned COL_W      = 9;
    localparam int unsigned DIM_W      = 11;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 11;

    localparam int unsigned ROWPROD_W  = ROW_W + DIM_W;
    localparam int unsigned COLPROD_W  = COL_W + 1 + DIM_W;
    localparam int unsigned SIZE_W     = 2 * DIM_W;
    localparam int unsigned LIN_W      = 2 * DIM_W + 1;
    localparam int unsigned COL_DIV    = 2 * OUT_WIDTH;

    // item kinds
    localparam logic [1:0] KIND_PAL_WR  = 2'd0;
    localparam logic [1:0] KIND_SKIN_WR = 2'd1;
    localparam logic [1:0] KIND_FETCH   = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER_COLORS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_START     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM_START  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIN_WIDTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIN_HEIGHT   = 3'd4;

    typedef struct packed {
        logic [7:0]       player_colors;
        logic [7:0]       top_start;
        logic [7:0]       bottom_start;
        logic [DIM_W-1:0] skin_width;
        logic [DIM_W-1:0] skin_height;
    } t_cfg;

    typedef struct packed {
        logic               valid;
        logic [1:0]         kind;
        logic               err;
        logic [SKIN_AW-1:0] raddr;
        logic [ADDR_W-1:0]  address;
        logic [COLOR_W-1:0] color;
        logic [TEXEL_W-1:0] texel;
    } t_stage_b;

    typedef struct packed {
        logic               valid;
        logic [1:0]         kind;
        logic               err;
        logic [PAL_AW-1:0]  pal_addr;
        logic [COLOR_W-1:0] color;
    } t_stage_c;

endpackage

[sv/sctr_if.sv]
interface sctr_in_if;
    import sctr_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  address;
    logic [COLOR_W-1:0] palette_color;
    logic [TEXEL_W-1:0] texel;
    logic [ROW_W-1:0]   out_row;
    logic [COL_W-1:0]   out_col;

    modport source (output valid, kind, address, palette_color, texel, out_row, out_col,
                    input ready);
    modport sink (input valid, kind, address, palette_color, texel, out_row, out_col,
                  output ready);
endinterface

interface sctr_pix_if;
    import sctr_pkg::*;
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] pixel_color;
    logic               size_error;

    modport source (output valid, pixel_color, size_error, input ready);
    modport sink (input valid, pixel_color, size_error, output ready);
endinterface

interface sctr_cfg_if;
    import sctr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/sctr_addr_gen.sv]
module sctr_addr_gen (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  sctr_pkg::t_cfg    i_cfg,
    sctr_in_if.sink           i_in,
    output sctr_pkg::t_stage_b o_b
);
    import sctr_pkg::*;

    logic [ROW_W-1:0]     w_row;
    logic [COL_W-1:0]     w_col;

    logic                 r_a_valid;
    logic [1:0]           r_a_kind;
    logic [ADDR_W-1:0]    r_a_address;
    logic [COLOR_W-1:0]   r_a_color;
    logic [TEXEL_W-1:0]   r_a_texel;
    logic [SIZE_W-1:0]    r_a_size;
    logic [ROWPROD_W-1:0] r_a_rowprod;
    logic [COLPROD_W-1:0] r_a_colprod;

    logic [DIM_W-1:0]     w_srow;
    logic [DIM_W-1:0]     w_scol;
    logic [SIZE_W-1:0]    w_rowbase;
    logic [LIN_W-1:0]     w_lin;
    logic                 w_err;
    t_stage_b             n_b;
    t_stage_b             r_b;

    assign i_in.ready = i_adv;

    // clamp to the output image
    always_comb begin
        w_row = (32'(i_in.out_row) > 32'(OUT_HEIGHT - 1)) ? ROW_W'(OUT_HEIGHT - 1) : i_in.out_row;
        w_col = (32'(i_in.out_col) > 32'(OUT_WIDTH - 1)) ? COL_W'(OUT_WIDTH - 1) : i_in.out_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_adv) begin
            r_a_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_kind    <= i_in.kind;
            r_a_address <= i_in.address;
            r_a_color   <= i_in.palette_color;
            r_a_texel   <= i_in.texel;
            r_a_size    <= SIZE_W'(i_cfg.skin_width) * SIZE_W'(i_cfg.skin_height);
            r_a_rowprod <= ROWPROD_W'(w_row) * ROWPROD_W'(i_cfg.skin_height);
            r_a_colprod <= COLPROD_W'({w_col, 1'b1}) * COLPROD_W'(i_cfg.skin_width);
        end
    end

    // nearest-neighbour source address
    always_comb begin
        w_srow    = DIM_W'(r_a_rowprod / OUT_HEIGHT);
        w_scol    = DIM_W'(r_a_colprod / COL_DIV);
        w_rowbase = SIZE_W'(w_srow) * SIZE_W'(i_cfg.skin_width);
        w_lin     = LIN_W'(w_rowbase) + LIN_W'(w_scol);
        w_err     = (r_a_size[1:0] != 2'b00) || (32'(r_a_size) > SKIN_DEPTH);

        n_b         = r_b;
        n_b.valid   = r_a_valid;
        n_b.kind    = r_a_kind;
        n_b.err     = w_err;
        n_b.raddr   = (32'(w_lin) >= SKIN_DEPTH) ? '0 : SKIN_AW'(w_lin);
        n_b.address = r_a_address;
        n_b.color   = r_a_color;
        n_b.texel   = r_a_texel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b.valid <= 1'b0;
        end else if (i_adv) begin
            r_b.valid   <= n_b.valid;
            r_b.kind    <= n_b.kind;
            r_b.err     <= n_b.err;
            r_b.raddr   <= n_b.raddr;
            r_b.address <= n_b.address;
            r_b.color   <= n_b.color;
            r_b.texel   <= n_b.texel;
        end
    end

    assign o_b = r_b;

endmodule

[sv/sctr_skin_mem.sv]
module sctr_skin_mem (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  sctr_pkg::t_stage_b           i_b,
    output sctr_pkg::t_stage_c           o_c,
    output logic [sctr_pkg::TEXEL_W-1:0] o_texel
);
    import sctr_pkg::*;

    logic [TEXEL_W-1:0] r_skin_mem [SKIN_DEPTH];
    logic [TEXEL_W-1:0] r_texel;
    logic               w_wr;
    t_stage_c           r_c;

    // writes past the store are dropped
    assign w_wr = i_b.valid && (i_b.kind == KIND_SKIN_WR) && (32'(i_b.address) < SKIN_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (w_wr) begin
                r_skin_mem[SKIN_AW'(i_b.address)] <= i_b.texel;
            end
            r_texel <= r_skin_mem[i_b.raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c.valid <= 1'b0;
        end else if (i_adv) begin
            r_c.valid    <= i_b.valid;
            r_c.kind     <= i_b.kind;
            r_c.err      <= i_b.err;
            r_c.pal_addr <= i_b.address[PAL_AW-1:0];
            r_c.color    <= i_b.color;
        end
    end

    assign o_c     = r_c;
    assign o_texel = r_texel;

endmodule

[sv/sctr_pal_lut.sv]
module sctr_pal_lut (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  sctr_pkg::t_cfg               i_cfg,
    input  sctr_pkg::t_stage_c           i_c,
    input  logic [sctr_pkg::TEXEL_W-1:0] i_texel,
    output logic                         o_valid,
    output logic [sctr_pkg::COLOR_W-1:0] o_pixel,
    output logic                         o_err
);
    import sctr_pkg::*;

    logic [COLOR_W-1:0] r_pal_mem [2**PAL_AW];
    logic [COLOR_W-1:0] r_color;
    logic               r_err;
    logic               r_out_valid;

    logic [7:0]         w_bot_d;
    logic [7:0]         w_top_d;
    logic [PAL_AW-1:0]  w_idx;

    // range bases have a zero low nibble, so base+d keeps d in the low nibble
    // and the reversed form base+15-d is just ~d there
    always_comb begin
        w_bot_d = i_texel - i_cfg.bottom_start;
        w_top_d = i_texel - i_cfg.top_start;
        priority if (w_bot_d[7:4] == 4'h0) begin
            w_idx = {i_cfg.player_colors[3:0],
                     i_cfg.player_colors[3] ? ~w_bot_d[3:0] : w_bot_d[3:0]};
        end else if (w_top_d[7:4] == 4'h0) begin
            w_idx = {i_cfg.player_colors[7:4],
                     i_cfg.player_colors[7] ? ~w_top_d[3:0] : w_top_d[3:0]};
        end else begin
            w_idx = i_texel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (i_c.valid && (i_c.kind == KIND_PAL_WR)) begin
                r_pal_mem[i_c.pal_addr] <= i_c.color;
            end
            r_color <= r_pal_mem[w_idx];
            r_err   <= i_c.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= i_c.valid && (i_c.kind == KIND_FETCH);
        end
    end

    assign o_valid = r_out_valid;
    assign o_pixel = r_err ? '0 : r_color;
    assign o_err   = r_err;

`ifndef NO_ASSERTIONS
    a_result_from_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_c.valid && (i_c.kind == KIND_FETCH)))
        else $error("result raised without a fetch behind it");
`endif

endmodule

[sv/skin_color_translate_scaler.sv]
// From an input transfer to result valid, the transfer edge loads the input register,
// then the address stage, skin read and palette read registers follow in that order.
// Throughput: one item per cycle; any output stall freezes every stage at once.
// Palette and skin writes give no result and ride the same pipe, so they
// take effect in order with fetches.
// Reset clears all valid bits and loads the register defaults; stores keep no reset.
module skin_color_translate_scaler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sctr_in_if.sink    i_in,
    sctr_pix_if.source o_pix,
    sctr_cfg_if.sink   i_cfg
);
    import sctr_pkg::*;

    t_cfg     r_cfg;
    logic     w_adv;
    logic     w_out_valid;
    t_stage_b w_b;
    t_stage_c w_c;
    logic [TEXEL_W-1:0] w_texel;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.player_colors <= 8'd0;
            r_cfg.top_start     <= 8'd16;
            r_cfg.bottom_start  <= 8'd96;
            r_cfg.skin_width    <= DIM_W'(296);
            r_cfg.skin_height   <= DIM_W'(194);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_PLAYER_COLORS: r_cfg.player_colors <= i_cfg.data[7:0];
                CFG_TOP_START:     r_cfg.top_start     <= i_cfg.data[7:0];
                CFG_BOTTOM_START:  r_cfg.bottom_start  <= i_cfg.data[7:0];
                CFG_SKIN_WIDTH:    r_cfg.skin_width    <= i_cfg.data[DIM_W-1:0];
                CFG_SKIN_HEIGHT:   r_cfg.skin_height   <= i_cfg.data[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_adv = !w_out_valid || o_pix.ready;

    sctr_addr_gen u_addr_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .o_b     (w_b)
    );

    sctr_skin_mem u_skin_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_b     (w_b),
        .o_c     (w_c),
        .o_texel (w_texel)
    );

    sctr_pal_lut u_pal_lut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_cfg   (r_cfg),
        .i_c     (w_c),
        .i_texel (w_texel),
        .o_valid (w_out_valid),
        .o_pixel (o_pix.pixel_color),
        .o_err   (o_pix.size_error)
    );

    assign o_pix.valid = w_out_valid;

`ifndef NO_ASSERTIONS
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && !o_pix.ready) |-> !i_in.ready)
        else $error("input taken while the output is stalled");

    a_error_pixel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pix.valid && o_pix.size_error) |-> (o_pix.pixel_color == '0))
        else $error("size error with a non-zero pixel");
`endif

endmodule
